FILE: design/kop_pkg.sv
`default_nettype none
package kop_pkg;

   localparam int PROB_W = 17;
   localparam int THR_W  = 5;

   localparam logic [PROB_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [PROB_W-1:0] ZERO_Q16 = 17'h00000;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 5'd1;

   typedef enum logic {
      KOP_IDLE,
      KOP_UPDATE
   } kop_state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic mul_en;
      logic commit;
      logic clear;
   } kop_ctrl_type;

endpackage
`default_nettype wire

FILE: design/k_out_of_n_probability.sv
`default_nettype none
// Streams event probabilities (unsigned Q1.16, 65536 = 1.0, larger inputs saturate) into a
// chain of MAX_THRESHOLD cells, cell j holding the probability that at least j+1 events of
// the current set occurred. At acceptance of an item every cell registers its
// two truncated products, in the following cycle the cells add them and write the table,
// and the next beat is taken once that write is done. On a beat flagged last the block
// delivers entry k (csr threshold, saturated to MAX_THRESHOLD; k = 0 gives 1.0) in an
// output register and clears the table. Non-last beats are accepted while a result waits.
module k_out_of_n_probability #(
   parameter int MAX_THRESHOLD = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [kop_pkg::PROB_W-1:0]    req_probability,
   input  wire                          req_last,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [kop_pkg::PROB_W-1:0]   rsp_at_least_k,
   input  wire                          csr_wr_en,
   input  wire [kop_pkg::THR_W-1:0]     csr_wr_data
);

   localparam int KW = $clog2(MAX_THRESHOLD + 1);

   kop_pkg::kop_state_type       state_ff, state_in;
   kop_pkg::kop_ctrl_type        ctrl;
   logic [kop_pkg::THR_W-1:0]    threshold_ff;
   logic                         last_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kop_pkg::PROB_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [kop_pkg::PROB_W-1:0]   p_sat, q_sat;
   logic [KW-1:0]                ksel;
   logic [kop_pkg::PROB_W-1:0]   selected;
   logic                         accept;

   logic [kop_pkg::PROB_W-1:0]   entries    [MAX_THRESHOLD];
   logic [kop_pkg::PROB_W-1:0]   entry_next [MAX_THRESHOLD];

   assign p_sat  = (req_probability > kop_pkg::ONE_Q16) ? kop_pkg::ONE_Q16 : req_probability;
   assign q_sat  = kop_pkg::ONE_Q16 - p_sat;
   assign accept = req_valid && req_ready;

   for (genvar j = 0; j < MAX_THRESHOLD; j++) begin : g_cell
      logic [kop_pkg::PROB_W-1:0] below;
      if (j == 0) begin : g_first
         assign below = kop_pkg::ONE_Q16;
      end else begin : g_rest
         assign below = entries[j-1];
      end
      kop_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .p          (p_sat),
         .q          (q_sat),
         .below      (below),
         .entry      (entries[j]),
         .entry_next (entry_next[j])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kop_pkg::KOP_IDLE:   if (accept) state_in = kop_pkg::KOP_UPDATE;
         kop_pkg::KOP_UPDATE: state_in = kop_pkg::KOP_IDLE;
         default:             state_in = kop_pkg::KOP_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      ctrl.mul_en = 1'b0;
      ctrl.commit = 1'b0;
      ctrl.clear  = 1'b0;
      unique case (state_ff)
         kop_pkg::KOP_IDLE: begin
            // a last beat needs the output register free by the time it finishes
            req_ready   = !rsp_valid_ff || rsp_ready || !req_last;
            ctrl.mul_en = req_valid && req_ready;
         end
         kop_pkg::KOP_UPDATE: begin
            ctrl.commit = 1'b1;
            ctrl.clear  = last_ff;
         end
         default: ;
      endcase
   end

   // threshold saturated to the chain length
   always_comb begin
      if (int'(threshold_ff) > MAX_THRESHOLD) begin
         ksel = KW'(MAX_THRESHOLD);
      end else begin
         ksel = KW'(threshold_ff);
      end
   end

   always_comb begin
      selected = kop_pkg::ONE_Q16;
      for (int j = 0; j < MAX_THRESHOLD; j++) begin
         if (ksel == KW'(j + 1)) selected = entry_next[j];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.commit && last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = selected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kop_pkg::KOP_IDLE;
         threshold_ff <= kop_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) last_ff <= req_last;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_at_least_k = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/kop_cell.sv
`default_nettype none
module kop_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire kop_pkg::kop_ctrl_type    ctrl,
   input  wire [kop_pkg::PROB_W-1:0]     p,
   input  wire [kop_pkg::PROB_W-1:0]     q,
   input  wire [kop_pkg::PROB_W-1:0]     below,
   output logic [kop_pkg::PROB_W-1:0]    entry,
   output logic [kop_pkg::PROB_W-1:0]    entry_next
);

   logic [kop_pkg::PROB_W-1:0]   entry_ff, entry_in;
   logic [kop_pkg::PROB_W-1:0]   prod_a_ff, prod_a_in;
   logic [kop_pkg::PROB_W-1:0]   prod_b_ff, prod_b_in;
   logic [2*kop_pkg::PROB_W-1:0] full_a, full_b;
   logic [kop_pkg::PROB_W:0]     sum;

   // each product truncated on its own
   assign full_a    = p * below;
   assign full_b    = q * entry_ff;
   assign prod_a_in = full_a[kop_pkg::PROB_W+15:16];
   assign prod_b_in = full_b[kop_pkg::PROB_W+15:16];

   assign sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};

   always_comb begin
      if (sum > {1'b0, kop_pkg::ONE_Q16}) begin
         entry_next = kop_pkg::ONE_Q16;
      end else begin
         entry_next = sum[kop_pkg::PROB_W-1:0];
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.commit) begin
         entry_in = ctrl.clear ? kop_pkg::ZERO_Q16 : entry_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= kop_pkg::ZERO_Q16;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

FILE: test/kop_tail_checker.sv
module kop_tail_checker #(
   parameter int MAX_THRESHOLD = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [kop_pkg::PROB_W-1:0] req_probability,
   input  wire logic                       req_last,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [kop_pkg::PROB_W-1:0] rsp_at_least_k,
   input  wire logic                       csr_wr_en,
   input  wire logic [kop_pkg::THR_W-1:0]  csr_wr_data,
   output int                              error_count,
   output int                              pending_count,
   output int                              results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import kop_pkg::*;

   localparam int FRAC_BITS = 16;

   // entry j holds P(at least j+1 events so far); P(at least 0) (certainty) is implicit
   logic [PROB_W-1:0] tail_prob [MAX_THRESHOLD];
   logic [THR_W-1:0]  threshold_q;
   logic [PROB_W-1:0] at_least_k_due [$];

   function automatic logic [PROB_W-1:0] mix_pair(input logic [PROB_W-1:0] p,
                                                  input logic [PROB_W-1:0] q,
                                                  input logic [PROB_W-1:0] lower,
                                                  input logic [PROB_W-1:0] self);
      logic [2*PROB_W-1:0] from_lower;
      logic [2*PROB_W-1:0] from_self;
      logic [2*PROB_W:0]   total;
      from_lower = ({{PROB_W{1'b0}}, p} * {{PROB_W{1'b0}}, lower}) >> FRAC_BITS;
      from_self  = ({{PROB_W{1'b0}}, q} * {{PROB_W{1'b0}}, self}) >> FRAC_BITS;
      total = {1'b0, from_lower} + {1'b0, from_self};
      return (total > ONE_Q16) ? ONE_Q16 : total[PROB_W-1:0];
   endfunction

   task automatic absorb_event(input logic [PROB_W-1:0] raw, input logic is_last);
      logic [PROB_W-1:0] p;
      logic [PROB_W-1:0] q;
      logic [PROB_W-1:0] below;
      logic [PROB_W-1:0] self;
      int unsigned       k;
      p = (raw > ONE_Q16) ? ONE_Q16 : raw;
      q = ONE_Q16 - p;
      below = ONE_Q16;
      // every entry uses old neighbors
      for (int j = 0; j < MAX_THRESHOLD; j++) begin
         self = tail_prob[j];
         tail_prob[j] = mix_pair(p, q, below, self);
         below = self;
      end
      if (is_last) begin
         k = (int'(threshold_q) > MAX_THRESHOLD) ? MAX_THRESHOLD : int'(threshold_q);
         if (k == 0)
            at_least_k_due.push_back(ONE_Q16);
         else
            at_least_k_due.push_back(tail_prob[k-1]);
         foreach (tail_prob[j])
            tail_prob[j] = ZERO_Q16;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] at_least_k mismatch: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic [PROB_W-1:0] want;
      if (reset) begin
         foreach (tail_prob[j])
            tail_prob[j] = ZERO_Q16;
         threshold_q = THRESHOLD_RESET;
         at_least_k_due.delete();
      end else begin
         if (csr_wr_en)
            threshold_q = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (at_least_k_due.size() == 0) begin
               report_mismatch($sformatf("beat %0d arrived with no set closed",
                                         rsp_at_least_k));
            end else begin
               want = at_least_k_due.pop_front();
               results_checked++;
               if (rsp_at_least_k !== want)
                  report_mismatch($sformatf("got %0d, want %0d (result %0d)",
                                            rsp_at_least_k, want, results_checked));
            end
         end
         if (req_valid && req_ready)
            absorb_event(req_probability, req_last);
      end
      pending_count <= at_least_k_due.size();
   end

endmodule

FILE: test/k_out_of_n_probability_tb.sv
module k_out_of_n_probability_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kop_pkg::*;

   localparam int MAX_THRESHOLD = 16;
   localparam int EVENT_TARGET  = 1850;
   localparam int DRAIN_CYCLES  = 4;
   localparam int QUIET_LIMIT   = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [PROB_W-1:0] req_probability = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [PROB_W-1:0] rsp_at_least_k;
   logic              csr_wr_en = 1'b0;
   logic [THR_W-1:0]  csr_wr_data = '0;

   int error_count;
   int pending_count;
   int results_checked;

   int events_sent;
   int sets_sent;
   int threshold_writes;
   int burst_left;
   int quiet_cycles;
   int ready_run;
   int unsigned ready_mode;
   logic [THR_W-1:0] cur_threshold = THRESHOLD_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   k_out_of_n_probability #(
      .MAX_THRESHOLD(MAX_THRESHOLD)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_probability(req_probability),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_at_least_k (rsp_at_least_k),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   kop_tail_checker #(
      .MAX_THRESHOLD(MAX_THRESHOLD)
   ) tail_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_probability(req_probability),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_at_least_k (rsp_at_least_k),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .results_checked(results_checked)
   );

   // result side: long ready runs, per-cycle coin flips, short and long stalls
   always @(posedge clock) begin
      if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else begin
         ready_mode = $urandom_range(0, 9);
         if (ready_mode < 3) begin
            rsp_ready <= 1'b1;
            ready_run <= $urandom_range(20, 200);
         end else if (ready_mode < 6) begin
            rsp_ready <= 1'($urandom_range(0, 1));
            ready_run <= 0;
         end else if (ready_mode < 9) begin
            rsp_ready <= 1'b0;
            ready_run <= $urandom_range(1, 8);
         end else begin
            rsp_ready <= 1'b0;
            ready_run <= $urandom_range(20, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sender gaps between bursts
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_beat(input logic [PROB_W-1:0] prob, input logic is_last);
      req_valid       <= 1'b1;
      req_probability <= prob;
      req_last        <= is_last;
      do @(posedge clock); while (!req_ready);
      events_sent++;
      if (is_last)
         sets_sent++;
      pace();
   endtask

   // hold off until every set result is back and the datapath is quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_threshold = value;
      threshold_writes++;
   endtask

   function automatic logic [PROB_W-1:0] pick_probability();
      case ($urandom_range(0, 19))
         0:       return ZERO_Q16;
         1:       return ONE_Q16;
         2:       return PROB_W'($urandom_range(32'h10001, 32'h1FFFF));
         3:       return PROB_W'($urandom_range(60000, 65536));
         4:       return PROB_W'($urandom_range(0, 5000));
         default: return PROB_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic run_set();
      int effective;
      int len;
      bit change_midway;
      effective = (int'(cur_threshold) > MAX_THRESHOLD) ? MAX_THRESHOLD : int'(cur_threshold);
      if ($urandom_range(0, 7) == 0)
         len = $urandom_range(1, 24);
      else
         len = $urandom_range(1, effective + 3);
      change_midway = ($urandom_range(0, 11) == 0) && (len > 1);
      for (int i = 0; i < len; i++) begin
         if (change_midway && i == len / 2)
            write_threshold(THR_W'($urandom_range(0, 31)));
         send_beat(pick_probability(), i == len - 1);
      end
   endtask

   initial begin
      int sets_in_phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // k = 1 out of reset: empty-ish sets, certainty, saturated inputs
      send_beat(ZERO_Q16, 1'b1);
      send_beat(ONE_Q16, 1'b1);
      send_beat(17'h1FFFF, 1'b1);
      send_beat(17'h10001, 1'b0);
      send_beat(17'h0FFFF, 1'b1);
      // k = 0 always yields certainty
      write_threshold(5'd0);
      send_beat(17'd12345, 1'b1);
      // full table depth
      write_threshold(THR_W'(MAX_THRESHOLD));
      repeat (MAX_THRESHOLD - 1) send_beat(ONE_Q16, 1'b0);
      send_beat(ONE_Q16, 1'b1);
      // k beyond the table saturates
      write_threshold(5'd31);
      send_beat(17'h1FFFF, 1'b0);
      send_beat(17'h0FFFF, 1'b1);

      while (events_sent < EVENT_TARGET) begin
         case ($urandom_range(0, 7))
            0:       write_threshold(5'd0);
            1:       write_threshold(5'd1);
            2:       write_threshold(THR_W'(MAX_THRESHOLD));
            3:       write_threshold(5'd31);
            4:       write_threshold(THR_W'($urandom_range(MAX_THRESHOLD + 1, 31)));
            default: write_threshold(THR_W'($urandom_range(2, MAX_THRESHOLD - 1)));
         endcase
         sets_in_phase = $urandom_range(3, 12);
         repeat (sets_in_phase) run_set();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);

      $display("run: %0d probability beats in %0d sets, %0d results checked",
               events_sent, sets_sent, results_checked);
      $display("run: %0d threshold writes incl. k = 0, full depth and saturated k",
               threshold_writes);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
